### hdl/ihex_pkg.sv
// Shared types, result and error codes and the hex digit decoder for the Intel HEX parser.
package ihex_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [2:0] err_t;
  typedef logic [1:0] run_t;

  localparam kind_t KIND_WRITE = 2'd0;
  localparam kind_t KIND_EOF   = 2'd1;
  localparam kind_t KIND_ERROR = 2'd2;

  localparam err_t ERR_BAD_START = 3'd0;
  localparam err_t ERR_BAD_HEX   = 3'd1;
  localparam err_t ERR_BAD_TYPE  = 3'd2;
  localparam err_t ERR_OVERFLOW  = 3'd3;
  localparam err_t ERR_CHECKSUM  = 3'd4;

  localparam run_t RUN_GOING = 2'd0;
  localparam run_t RUN_DONE  = 2'd1;
  localparam run_t RUN_ERROR = 2'd2;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam logic [7:0] REC_DATA   = 8'h00;
  localparam logic [7:0] REC_EOF    = 8'h01;
  localparam logic [7:0] REC_SEG    = 8'h02;
  localparam logic [7:0] REC_LINEAR = 8'h04;
  localparam logic [7:0] REC_START  = 8'h05;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t r;
    r.ok = 1'b1;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.value = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.value = 4'(c - 8'h57);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

### hdl/intel_hex_record_parser.sv
// Intel HEX record parser: one character a beat in, memory writes, end and error results out.
//
// The parser takes one character of Intel HEX text a beat and accepts a new character in every
// cycle that the output register is free: each character is decoded into the record state and,
// where it produces one, a result that is held in an output register. A new character is taken
// while that register is empty or its result is being taken in the same cycle, so the
// sustained rate is one character per cycle whenever the consumer keeps up. Data records give
// one write result per payload byte; end of file and errors give a single result, after which
// all further characters are taken and dropped until reset. The lowest and highest written
// addresses travel with every result.
module intel_hex_record_parser
  import ihex_pkg::*;
#(
  parameter int unsigned MEM_BYTES = 16777216
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [23:0] address,
  output logic [7:0]  data,
  output logic [2:0]  error_code,
  output logic [23:0] lowest_address,
  output logic [23:0] highest_address
);

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_COUNT  = 3'd1;
  localparam logic [2:0] PH_OFFSET = 3'd2;
  localparam logic [2:0] PH_TYPE   = 3'd3;
  localparam logic [2:0] PH_BASE   = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;
  localparam logic [2:0] PH_CHECK  = 3'd6;
  localparam logic [2:0] PH_SKIP   = 3'd7;

  localparam logic [24:0] MEM_LIMIT = 25'(MEM_BYTES);

  logic [2:0]  phase, phase_next;
  logic [2:0]  nibble_count, nibble_count_next;
  logic [15:0] field_value, field_value_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [16:0] record_offset, record_offset_next;
  logic [7:0]  record_type, record_type_next;
  logic [7:0]  bytes_done, bytes_done_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [23:0] base_address, base_address_next;
  logic [23:0] min_written, min_written_next;
  logic [23:0] max_written, max_written_next;
  run_t        finished, finished_next;

  logic        emit;
  kind_t       emit_kind;
  logic [23:0] emit_address;
  logic [7:0]  emit_data;
  err_t        emit_code;

  logic        take;
  hex_t        digit;
  logic [15:0] shifted;
  logic [2:0]  nibble_inc;
  logic        field_done;
  logic [24:0] write_addr;
  logic [7:0]  done_inc;

  assign in_ready = !out_valid || out_ready;
  assign take = in_valid && in_ready;

  assign digit      = hex_digit(char_in);
  assign shifted    = {field_value[11:0], digit.value};
  assign nibble_inc = nibble_count + 3'd1;
  assign field_done = (phase == PH_OFFSET || phase == PH_BASE) ? (nibble_inc == 3'd4)
                                                               : (nibble_inc == 3'd2);
  assign write_addr = {1'b0, base_address} + {8'd0, record_offset};
  assign done_inc   = bytes_done + 8'd1;

  always_comb begin
    phase_next         = phase;
    nibble_count_next  = nibble_count;
    field_value_next   = field_value;
    byte_count_next    = byte_count;
    record_offset_next = record_offset;
    record_type_next   = record_type;
    bytes_done_next    = bytes_done;
    running_sum_next   = running_sum;
    base_address_next  = base_address;
    min_written_next   = min_written;
    max_written_next   = max_written;
    finished_next      = finished;
    emit               = 1'b0;
    emit_kind          = KIND_WRITE;
    emit_address       = 24'd0;
    emit_data          = 8'd0;
    emit_code          = ERR_BAD_START;

    if (take && finished == RUN_GOING) begin
      unique case (phase)
        PH_START: begin
          if (char_in != CHAR_COLON) begin
            finished_next = RUN_ERROR;
            emit = 1'b1;
            emit_kind = KIND_ERROR;
            emit_code = ERR_BAD_START;
          end else begin
            phase_next        = PH_COUNT;
            nibble_count_next = 3'd0;
            field_value_next  = 16'd0;
            running_sum_next  = 8'd0;
            bytes_done_next   = 8'd0;
          end
        end
        PH_SKIP: begin
          if (char_in == CHAR_LF) begin
            phase_next = PH_START;
          end
        end
        default: begin
          if (!digit.ok) begin
            finished_next = RUN_ERROR;
            emit = 1'b1;
            emit_kind = KIND_ERROR;
            emit_code = ERR_BAD_HEX;
          end else if (!field_done) begin
            field_value_next  = shifted;
            nibble_count_next = nibble_inc;
          end else begin
            field_value_next  = 16'd0;
            nibble_count_next = 3'd0;
            unique case (phase)
              PH_COUNT: begin
                byte_count_next  = shifted[7:0];
                running_sum_next = shifted[7:0];
                phase_next       = PH_OFFSET;
              end
              PH_OFFSET: begin
                record_offset_next = {1'b0, shifted};
                running_sum_next   = running_sum + shifted[15:8] + shifted[7:0];
                phase_next         = PH_TYPE;
              end
              PH_TYPE: begin
                record_type_next = shifted[7:0];
                running_sum_next = running_sum + shifted[7:0];
                unique case (shifted[7:0]) inside
                  REC_EOF: begin
                    finished_next = RUN_DONE;
                    emit = 1'b1;
                    emit_kind = KIND_EOF;
                  end
                  REC_SEG, REC_LINEAR: phase_next = PH_BASE;
                  REC_START: phase_next = PH_SKIP;
                  REC_DATA: phase_next = (byte_count != 8'd0) ? PH_DATA : PH_CHECK;
                  default: begin
                    finished_next = RUN_ERROR;
                    emit = 1'b1;
                    emit_kind = KIND_ERROR;
                    emit_code = ERR_BAD_TYPE;
                  end
                endcase
              end
              PH_BASE: begin
                if (record_type == REC_SEG) begin
                  base_address_next = {4'd0, shifted, 4'd0};
                end else begin
                  base_address_next = {shifted[7:0], 16'd0};
                end
                phase_next = PH_SKIP;
              end
              PH_DATA: begin
                if (write_addr >= MEM_LIMIT) begin
                  finished_next = RUN_ERROR;
                  emit = 1'b1;
                  emit_kind = KIND_ERROR;
                  emit_code = ERR_OVERFLOW;
                end else begin
                  if (write_addr[23:0] < min_written) min_written_next = write_addr[23:0];
                  if (write_addr[23:0] > max_written) max_written_next = write_addr[23:0];
                  running_sum_next   = running_sum + shifted[7:0];
                  record_offset_next = record_offset + 17'd1;
                  bytes_done_next    = done_inc;
                  if (done_inc == byte_count) phase_next = PH_CHECK;
                  emit = 1'b1;
                  emit_kind = KIND_WRITE;
                  emit_address = write_addr[23:0];
                  emit_data = shifted[7:0];
                end
              end
              PH_CHECK: begin
                if (8'(running_sum + shifted[7:0]) != 8'd0) begin
                  finished_next = RUN_ERROR;
                  emit = 1'b1;
                  emit_kind = KIND_ERROR;
                  emit_code = ERR_CHECKSUM;
                end else begin
                  phase_next = PH_SKIP;
                end
              end
              default: phase_next = PH_SKIP;
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      nibble_count  <= 3'd0;
      field_value   <= 16'd0;
      byte_count    <= 8'd0;
      record_offset <= 17'd0;
      record_type   <= 8'd0;
      bytes_done    <= 8'd0;
      running_sum   <= 8'd0;
      base_address  <= 24'd0;
      min_written   <= 24'hFFFFFF;
      max_written   <= 24'd0;
      finished      <= RUN_GOING;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      nibble_count  <= nibble_count_next;
      field_value   <= field_value_next;
      byte_count    <= byte_count_next;
      record_offset <= record_offset_next;
      record_type   <= record_type_next;
      bytes_done    <= bytes_done_next;
      running_sum   <= running_sum_next;
      base_address  <= base_address_next;
      min_written   <= min_written_next;
      max_written   <= max_written_next;
      finished      <= finished_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind            <= emit_kind;
      address         <= emit_address;
      data            <= emit_data;
      error_code      <= emit_code;
      lowest_address  <= min_written_next;
      highest_address <= max_written_next;
    end
  end

endmodule

### test/tb_intel_hex_record_parser.sv
// Self-checking testbench for the Intel HEX record parser: whole hex files sent a character a beat.
module tb_intel_hex_record_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import ihex_pkg::*;

  typedef enum logic [3:0] {
    PH_START, PH_COUNT, PH_OFFSET, PH_TYPE, PH_BASE, PH_DATA, PH_CHECK, PH_SKIP
  } parse_phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [23:0] address;
    logic [7:0]  data;
    err_t        error_code;
    logic [23:0] lowest;
    logic [23:0] highest;
  } hex_result_t;

  localparam logic [24:0] MEM_LIMIT = 25'h1000000;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = 20;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_in = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [23:0] address;
  logic [7:0]  data;
  logic [2:0]  error_code;
  logic [23:0] lowest_address;
  logic [23:0] highest_address;

  parse_phase_t rec_phase;
  logic [2:0]   nib_cnt;
  logic [15:0]  field_acc;
  logic [7:0]   rec_count;
  logic [16:0]  rec_offset;
  logic [7:0]   rec_type;
  logic [7:0]   rec_done;
  logic [7:0]   rec_sum;
  logic [23:0]  base_addr;
  logic [23:0]  low_mark;
  logic [23:0]  high_mark;
  run_t         run_state;

  hex_result_t expected_results[$];
  hex_result_t want_r;
  logic [7:0]  payload_buf[256];
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          chars_sent = 0;
  int          results_seen = 0;
  int          writes_seen = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  string       end_name = "nothing";

  intel_hex_record_parser dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_in        (char_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .address        (address),
    .data           (data),
    .error_code     (error_code),
    .lowest_address (lowest_address),
    .highest_address(highest_address)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void reset_model();
    rec_phase  = PH_START;
    nib_cnt    = '0;
    field_acc  = '0;
    rec_count  = '0;
    rec_offset = '0;
    rec_type   = '0;
    rec_done   = '0;
    rec_sum    = '0;
    base_addr  = '0;
    low_mark   = 24'hFFFFFF;
    high_mark  = '0;
    run_state  = RUN_GOING;
  endfunction

  function automatic int hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
    return -1;
  endfunction

  function automatic hex_result_t pack_result(input kind_t k, input logic [23:0] a,
                                              input logic [7:0] b, input err_t e);
    hex_result_t r;
    r.kind       = k;
    r.address    = a;
    r.data       = b;
    r.error_code = e;
    r.lowest     = low_mark;
    r.highest    = high_mark;
    return r;
  endfunction

  function automatic hex_result_t raise_error(input err_t e);
    run_state = RUN_ERROR;
    return pack_result(KIND_ERROR, '0, '0, e);
  endfunction

  // Advances the parser state by one character; returns 1 when a result is due.
  function automatic bit parse_char(input logic [7:0] c, output hex_result_t r);
    int          d;
    logic [15:0] v;
    logic [24:0] a;
    r = '0;
    if (run_state != RUN_GOING) return 1'b0;
    if (rec_phase == PH_START) begin
      if (c != CHAR_COLON) begin
        r = raise_error(ERR_BAD_START);
        return 1'b1;
      end
      rec_phase = PH_COUNT;
      nib_cnt   = '0;
      field_acc = '0;
      rec_sum   = '0;
      rec_done  = '0;
      return 1'b0;
    end
    if (rec_phase == PH_SKIP) begin
      if (c == CHAR_LF) rec_phase = PH_START;
      return 1'b0;
    end
    d = hex_value(c);
    if (d < 0) begin
      r = raise_error(ERR_BAD_HEX);
      return 1'b1;
    end
    field_acc = {field_acc[11:0], d[3:0]};
    nib_cnt   = nib_cnt + 3'd1;
    if (nib_cnt < ((rec_phase == PH_OFFSET || rec_phase == PH_BASE) ? 3'd4 : 3'd2)) begin
      return 1'b0;
    end
    v         = field_acc;
    nib_cnt   = '0;
    field_acc = '0;
    case (rec_phase)
      PH_COUNT: begin
        rec_count = v[7:0];
        rec_sum   = v[7:0];
        rec_phase = PH_OFFSET;
      end
      PH_OFFSET: begin
        rec_offset = {1'b0, v};
        rec_sum    = rec_sum + v[15:8] + v[7:0];
        rec_phase  = PH_TYPE;
      end
      PH_TYPE: begin
        rec_type = v[7:0];
        rec_sum  = rec_sum + v[7:0];
        case (rec_type) inside
          REC_EOF: begin
            run_state = RUN_DONE;
            r = pack_result(KIND_EOF, '0, '0, '0);
            return 1'b1;
          end
          REC_SEG, REC_LINEAR: rec_phase = PH_BASE;
          REC_START: rec_phase = PH_SKIP;
          REC_DATA: rec_phase = (rec_count != 8'h00) ? PH_DATA : PH_CHECK;
          default: begin
            r = raise_error(ERR_BAD_TYPE);
            return 1'b1;
          end
        endcase
      end
      PH_BASE: begin
        if (rec_type == REC_SEG) base_addr = {4'h0, v, 4'h0};
        else base_addr = {v[7:0], 16'h0000};
        rec_phase = PH_SKIP;
      end
      PH_DATA: begin
        a = {1'b0, base_addr} + {8'h00, rec_offset};
        if (a >= MEM_LIMIT) begin
          r = raise_error(ERR_OVERFLOW);
          return 1'b1;
        end
        if (a[23:0] < low_mark) low_mark = a[23:0];
        if (a[23:0] > high_mark) high_mark = a[23:0];
        rec_sum    = rec_sum + v[7:0];
        rec_offset = rec_offset + 17'd1;
        rec_done   = rec_done + 8'd1;
        if (rec_done == rec_count) rec_phase = PH_CHECK;
        r = pack_result(KIND_WRITE, a[23:0], v[7:0], '0);
        return 1'b1;
      end
      PH_CHECK: begin
        if (8'(rec_sum + v[7:0]) != 8'h00) begin
          r = raise_error(ERR_CHECKSUM);
          return 1'b1;
        end
        rec_phase = PH_SKIP;
      end
      default: rec_phase = PH_SKIP;
    endcase
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    end
  endtask

  task automatic send_char(input logic [7:0] c);
    hex_result_t r;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in  <= c;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
    if (parse_char(c, r)) expected_results.push_back(r);
  endtask

  task automatic send_hex_byte(input logic [7:0] b);
    logic [3:0] n;
    for (int i = 1; i >= 0; i--) begin
      n = b[i*4 +: 4];
      if (n < 4'd10) send_char(8'h30 + 8'(n));
      else if ($urandom_range(1) == 1) send_char(8'h57 + 8'(n));
      else send_char(8'h37 + 8'(n));
    end
  endtask

  task automatic send_line_end();
    logic [7:0] junk;
    if ($urandom_range(6) == 0) begin
      repeat ($urandom_range(4, 1)) begin
        junk = 8'($urandom_range(255));
        send_char((junk == CHAR_LF) ? 8'h20 : junk);
      end
    end
    if ($urandom_range(2) == 0) send_char(CHAR_CR);
    send_char(CHAR_LF);
  endtask

  task automatic send_record(input logic [7:0] rtype, input logic [7:0] count,
                             input logic [15:0] offset, input logic [7:0] cs_flip);
    logic [7:0] sum;
    sum = count + offset[15:8] + offset[7:0] + rtype;
    send_char(CHAR_COLON);
    send_hex_byte(count);
    send_hex_byte(offset[15:8]);
    send_hex_byte(offset[7:0]);
    send_hex_byte(rtype);
    for (int i = 0; i < int'(count); i++) begin
      sum = sum + payload_buf[i];
      send_hex_byte(payload_buf[i]);
    end
    send_hex_byte(8'(-sum) ^ cs_flip);
    send_line_end();
  endtask

  task automatic fill_payload(input int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(7))
        0: payload_buf[i] = 8'h00;
        1: payload_buf[i] = 8'hFF;
        default: payload_buf[i] = 8'($urandom);
      endcase
    end
  endtask

  // Keeps a well-formed data record below the top of memory.
  function automatic logic [15:0] safe_offset(input logic [15:0] offset, input int count);
    if (int'(base_addr) + int'(offset) + count > int'(MEM_LIMIT)) return 16'('h10000 - count);
    return offset;
  endfunction

  task automatic send_random_record();
    int          pick;
    int          count;
    logic [15:0] offset;
    pick = $urandom_range(99);
    case ($urandom_range(5))
      0: offset = 16'h0000;
      1: offset = 16'hFFFF;
      default: offset = 16'($urandom);
    endcase
    if (pick < 72) begin
      count = ($urandom_range(49) == 0) ? $urandom_range(255, 17) : $urandom_range(16, 1);
      fill_payload(count);
      send_record(REC_DATA, 8'(count), safe_offset(offset, count), 8'h00);
    end else if (pick < 82) begin
      fill_payload(2);
      send_record(REC_LINEAR, 8'd2, offset, 8'h00);
    end else if (pick < 90) begin
      fill_payload(2);
      send_record(REC_SEG, 8'd2, offset, 8'h00);
    end else if (pick < 95) begin
      fill_payload(4);
      send_record(REC_START, 8'd4, offset, 8'h00);
    end else begin
      send_record(REC_DATA, 8'd0, offset, 8'h00);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic test_directed_records();
    payload_buf[0] = 8'hFF;
    send_record(REC_DATA, 8'd1, 16'h0000, 8'h00);
    payload_buf[0] = 8'h00;
    payload_buf[1] = 8'hFF;
    send_record(REC_LINEAR, 8'd2, 16'h0000, 8'h00);
    payload_buf[0] = 8'h00;
    send_record(REC_DATA, 8'd1, 16'hFFFF, 8'h00);
    send_char(CHAR_COLON);
    repeat (5) send_hex_byte(8'h00);
    send_char(8'hFF);
    send_char(8'h00);
    send_char(CHAR_CR);
    send_char(CHAR_LF);
  endtask

  task automatic test_random_records();
    int target;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 84; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 84; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      target = chars_sent + 210;
      while (chars_sent < target) send_random_record();
      drain_results();
    end
  endtask

  task automatic test_end_of_parsing();
    logic [7:0] c;
    int         count;
    case ($urandom_range(5))
      0: begin
        end_name = "an end of file record";
        send_record(REC_EOF, 8'd0, 16'h0000, 8'h00);
      end
      1: begin
        end_name = "a bad start code";
        case ($urandom_range(2))
          0: c = 8'h20;
          1: c = CHAR_CR;
          default: do c = 8'($urandom); while (c == CHAR_COLON);
        endcase
        send_char(c);
      end
      2: begin
        end_name = "a bad hex digit";
        send_char(CHAR_COLON);
        repeat ($urandom_range(5)) send_char(8'h30 + 8'($urandom_range(9)));
        if ($urandom_range(3) == 0) c = CHAR_LF;
        else do c = 8'($urandom); while (hex_value(c) >= 0);
        send_char(c);
      end
      3: begin
        end_name = "an unknown record type";
        do c = 8'($urandom);
        while (c == REC_DATA || c == REC_EOF || c == REC_SEG || c == REC_LINEAR ||
               c == REC_START);
        fill_payload(2);
        send_record(c, 8'd2, 16'($urandom), 8'h00);
      end
      4: begin
        end_name = "a write beyond the top of memory";
        payload_buf[0] = 8'h00;
        payload_buf[1] = 8'hFF;
        send_record(REC_LINEAR, 8'd2, 16'h0000, 8'h00);
        fill_payload(4);
        send_record(REC_DATA, 8'd4, 16'hFFFE, 8'h00);
      end
      default: begin
        end_name = "a checksum mismatch";
        count = $urandom_range(8);
        fill_payload(count);
        send_record(REC_DATA, 8'(count), safe_offset(16'($urandom), count),
                    8'($urandom_range(255, 1)));
      end
    endcase
  endtask

  task automatic test_ignored_after_end();
    send_char(CHAR_COLON);
    repeat (20) send_char(8'($urandom));
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with none expected, kind", 24'(kind), '0);
      end else begin
        want_r = expected_results.pop_front();
        if (want_r.kind == KIND_WRITE) writes_seen++;
        if (kind !== want_r.kind) report_mismatch("kind", 24'(kind), 24'(want_r.kind));
        if (address !== want_r.address) report_mismatch("address", address, want_r.address);
        if (data !== want_r.data) report_mismatch("data", 24'(data), 24'(want_r.data));
        if (error_code !== want_r.error_code) begin
          report_mismatch("error_code", 24'(error_code), 24'(want_r.error_code));
        end
        if (lowest_address !== want_r.lowest) begin
          report_mismatch("lowest_address", lowest_address, want_r.lowest);
        end
        if (highest_address !== want_r.highest) begin
          report_mismatch("highest_address", highest_address, want_r.highest);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no beat in either direction for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_records();
    test_random_records();
    test_end_of_parsing();
    test_ignored_after_end();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d characters and checked %0d results, %0d of them memory writes,",
             chars_sent, results_seen, writes_seen);
    $display("under four idling patterns; parsing was ended by %s.", end_name);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
